/* rtl/ultrasonic_echo_ranger_assert.svh */
// Assertion helpers for the top-level ranger file, which checks its own logic.
`ifndef ULTRASONIC_ECHO_RANGER_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define URE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define URE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ure_pkg.sv */
package ure_pkg;

  localparam int DIST_BITS = 20;
  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

  // Speed of sound as 1/256 cm per microsecond, scaled by 256.
  localparam int SPEED_BITS = 12;
  localparam logic [SPEED_BITS-1:0] SPEED_NUM = 12'd2251;

  localparam int PHASE_BITS = 4;
  localparam logic [PHASE_BITS-1:0] PHASE_IDLE = 4'd0;
  localparam logic [PHASE_BITS-1:0] PHASE_FIRST = 4'd1;
  localparam logic [PHASE_BITS-1:0] PHASE_LOW_END = 4'd2;
  localparam logic [PHASE_BITS-1:0] PHASE_LAST = 4'd12;

  localparam logic REG_DIRECT_CH0 = 1'b0;
  localparam logic REG_DIRECT_CH1 = 1'b1;

  typedef struct packed {
    logic [1:0] echo_levels;
    logic       read_request;
    logic       read_channel;
    logic       trigger_request;
    logic       trigger_channel;
  } in_t;

  typedef struct packed {
    logic [1:0]           trigger_lines;
    logic                 read_valid;
    logic                 out_of_range;
    logic [DIST_BITS-1:0] distance;
  } out_t;

  typedef struct packed {
    logic out_full;
    logic skid_full;
  } buf_status_t;

endpackage

/* rtl/ure_dist.sv */
module ure_dist #(
  parameter int WIDTH_BITS = 16
) (
  input  logic [WIDTH_BITS-1:0]        width,
  input  logic                         direct,
  output logic [ure_pkg::DIST_BITS-1:0] distance
);

  localparam int PW = WIDTH_BITS + ure_pkg::SPEED_BITS;

  logic [PW-1:0] product;
  logic [PW-1:0] scaled;

  assign product = PW'(width) * PW'(ure_pkg::SPEED_NUM);

  // A reflected path covers the distance twice, so it takes one more shift.
  assign scaled = direct ? (product >> 8) : (product >> 9);

  assign distance = (scaled > PW'(ure_pkg::DIST_MAX)) ? ure_pkg::DIST_MAX
                                                      : scaled[ure_pkg::DIST_BITS-1:0];

endmodule

/* rtl/ure_core.sv */
module ure_core #(
  parameter int CHANNELS   = 2,
  parameter int WIDTH_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  ure_pkg::in_t  word,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic          cfg_data,
  output ure_pkg::out_t result
);

  localparam logic [WIDTH_BITS-1:0] WIDTH_MAX = '1;

  logic direct_ch0;
  logic direct_ch1;
  logic [1:0] last_echo;
  logic [ure_pkg::PHASE_BITS-1:0] phase;
  logic [ure_pkg::PHASE_BITS-1:0] phase_next;
  logic target;
  logic target_next;

  logic [WIDTH_BITS-1:0] latched_after [CHANNELS];
  logic [CHANNELS-1:0]   ready_after;
  logic [CHANNELS-1:0]   rd_hit;

  logic [WIDTH_BITS-1:0] rd_width;
  logic                  rd_direct;
  logic [ure_pkg::DIST_BITS-1:0] rd_distance;
  logic [1:0]            lines;

  always_ff @(posedge clk) begin
    if (rst) begin
      direct_ch0 <= 1'b0;
      direct_ch1 <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ure_pkg::REG_DIRECT_CH0: direct_ch0 <= cfg_data;
        ure_pkg::REG_DIRECT_CH1: direct_ch1 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_echo <= 2'b00;
    end else if (step) begin
      last_echo <= word.echo_levels;
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
    logic [WIDTH_BITS-1:0] run_width;
    logic [WIDTH_BITS-1:0] run_next;
    logic [WIDTH_BITS-1:0] latched;
    logic                  ready;
    logic now_lvl;
    logic was_lvl;
    logic rise;
    logic fall;

    // Only the first two channels have echo pins; the rest never see an edge.
    assign now_lvl = (c < 2) ? word.echo_levels[c % 2] : 1'b0;
    assign was_lvl = (c < 2) ? last_echo[c % 2] : 1'b0;
    assign rise = now_lvl & ~was_lvl;
    assign fall = ~now_lvl & was_lvl;
    assign rd_hit[c] = (c < 2) && (word.read_channel == 1'(c % 2));

    assign run_next = rise ? '0 :
                      (run_width < WIDTH_MAX) ? run_width + 1'b1 : run_width;
    assign latched_after[c] = fall ? run_next : latched;
    assign ready_after[c] = fall | ready;

    always_ff @(posedge clk) begin
      if (rst) begin
        run_width <= '0;
        latched   <= '0;
        ready     <= 1'b0;
      end else if (step) begin
        run_width <= run_next;
        latched   <= latched_after[c];
        ready     <= ready_after[c] & ~(word.read_request & rd_hit[c]);
      end
    end
  end

  // The read sees this tick's edges, so a fall and a read together return the new width.
  always_comb begin
    rd_width = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (rd_hit[c] && ready_after[c]) begin
        rd_width = latched_after[c];
      end
    end
  end

  assign rd_direct = word.read_channel ? direct_ch1 : direct_ch0;

  ure_dist #(
    .WIDTH_BITS(WIDTH_BITS)
  ) u_dist (
    .width   (rd_width),
    .direct  (rd_direct),
    .distance(rd_distance)
  );

  always_comb begin
    phase_next  = phase;
    target_next = target;
    if (phase != ure_pkg::PHASE_IDLE) begin
      phase_next = (phase >= ure_pkg::PHASE_LAST) ? ure_pkg::PHASE_IDLE
                                                  : phase + 1'b1;
    end else if (word.trigger_request) begin
      phase_next  = ure_pkg::PHASE_FIRST;
      target_next = word.trigger_channel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= ure_pkg::PHASE_IDLE;
      target <= 1'b0;
    end else if (step) begin
      phase  <= phase_next;
      target <= target_next;
    end
  end

  assign lines = ((phase_next > ure_pkg::PHASE_LOW_END) && (CHANNELS > 1 || !target_next))
                 ? (2'b01 << target_next) : 2'b00;

  always_comb begin
    result.trigger_lines = lines;
    result.read_valid    = word.read_request;
    result.out_of_range  = word.read_request && (rd_width == '0);
    result.distance      = (word.read_request && (rd_width != '0)) ? rd_distance : '0;
  end

endmodule

/* rtl/ure_out_buf.sv */
module ure_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  ure_pkg::out_t        load_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ure_pkg::out_t        out_word,
  output ure_pkg::buf_status_t status
);

  logic          skid_valid;
  ure_pkg::out_t skid_word;
  logic          out_free;

  // The output register is free when empty or when its word leaves this cycle.
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= load;
      end
    end else if (load) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (load) begin
        out_word <= load_word;
      end
    end else if (load) begin
      skid_word <= load_word;
    end
  end

  assign status.out_full  = out_valid;
  assign status.skid_full = skid_valid;

endmodule

/* rtl/ultrasonic_echo_ranger.sv */
// Two-channel ultrasonic echo timer and trigger pulse generator.
// The input channel (in_valid, in_stall, in_word) carries one word per
// microsecond tick: the sampled echo levels plus optional read and trigger
// requests. Every accepted word yields exactly one output word on
// (out_valid, out_stall, out_word): the trigger line levels for that tick and,
// when a read was asked for, the distance in 1/256 cm or an out-of-range flag.
// An accepted word passes the input register, then the echo timers and distance
// multiplier, which load the output register, or the skid register while the
// output stalls. Throughput is one word per cycle while in_stall is low; the
// single width-by-2251 multiply sets the cycle path.
// When the receiver stalls, words collect in the output register and a skid
// register; in_stall rises only once the skid register holds a word, and
// drops again the cycle after the output moves on.
// Reset clears the timers, ready flags, trigger sequencer and both path
// configuration bits (reflected path). The configuration port (cfg_we,
// cfg_index, cfg_data) writes one bit per cycle and should be used idle.
`include "ultrasonic_echo_ranger_assert.svh"

module ultrasonic_echo_ranger #(
  parameter int CHANNELS   = 2,
  parameter int WIDTH_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  ure_pkg::in_t  in_word,
  output logic          out_valid,
  input  logic          out_stall,
  output ure_pkg::out_t out_word,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic          cfg_data
);

  logic                 stage_valid;
  ure_pkg::in_t         stage_word;
  logic                 step;
  ure_pkg::out_t        result;
  ure_pkg::buf_status_t status;

  assign in_stall = status.skid_full;
  assign step     = stage_valid && !status.skid_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!in_stall) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stage_word <= in_word;
    end
  end

  ure_core #(
    .CHANNELS  (CHANNELS),
    .WIDTH_BITS(WIDTH_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .word     (stage_word),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .result   (result)
  );

  ure_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .load     (step),
    .load_word(result),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .status   (status)
  );

  `URE_ASSERT_SAME(a_skid_behind_out, clk, rst, status.skid_full, status.out_full,
    "skid register holds a word while the output register is empty")
  `URE_ASSERT_NEXT(a_step_reaches_out, clk, rst, stage_valid && !in_stall, out_valid,
    "a word that left the input register did not reach the output")
  `URE_ASSERT_SAME(a_one_trigger_line, clk, rst, out_valid,
    $onehot0(out_word.trigger_lines), "more than one trigger line driven")
  `URE_ASSERT_SAME(a_oor_is_read, clk, rst, out_valid && out_word.out_of_range,
    out_word.read_valid && (out_word.distance == '0),
    "out-of-range word without a read or with a distance")

endmodule
